[src/fpe_pkg.sv]
// Package for the fingerprint module packet engine.
// Holds sizes, codes, reset values and the item structs; no dependencies.
`timescale 1ns / 1ps

package fpe_pkg;

    // Receive buffer geometry
    localparam int RX_DEPTH = 64;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int RX_CW    = $clog2(RX_DEPTH + 1);
    localparam int RX_IW    = RX_CW + 1;

    // Reply pattern and field offsets from pattern start
    localparam int PAT_LEN     = 7;
    localparam int CONFIRM_OFS = 9;
    localparam int FIELD_CNT   = 5;

    // Command packet layout
    localparam int MAX_PARAMS = 5;
    localparam int TX_FIXED   = 10;
    localparam int LEN_EXTRA  = 3;

    // Commands
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_IDLE = 2'd2;

    // Result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Mapped reply status
    localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [2:0] ST_DELETE_FAIL = 3'd4;
    localparam logic [2:0] ST_OTHER       = 3'd5;
    localparam logic [7:0] CODE_MAX_PLAIN = 8'h03;
    localparam logic [7:0] CODE_DELETE    = 8'h10;

    // Configuration register indexes
    localparam logic [1:0] REG_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_HEADER   = 2'd1;
    localparam logic [1:0] REG_CMD_FLAG = 2'd2;
    localparam logic [1:0] REG_RPL_FLAG = 2'd3;

    // Configuration reset values
    localparam logic [31:0] RST_ADDRESS  = 32'hFFFF_FFFF;
    localparam logic [15:0] RST_HEADER   = 16'hEF01;
    localparam logic [7:0]  RST_CMD_FLAG = 8'h01;
    localparam logic [7:0]  RST_RPL_FLAG = 8'h07;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  instruction;
        logic [2:0]  param_count;
        logic [39:0] param_data;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic        reply_found;
        logic [2:0]  reply_status;
        logic [7:0]  confirm_code;
        logic [15:0] page_number;
        logic [15:0] match_score;
    } t_out_item;

endpackage

[src/fingerprint_module_packet_engine.sv]
// Top level of the fingerprint module packet engine: framer, receive buffer, reply search.
// Depends on fpe_pkg and fpe_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one item per handshake.
//   A send item produces param_count+12 transmit items (param_count clamped to 5, so
//   at most 17), the last one flagged; they leave one per cycle through the output
//   register while the receiver takes them.
//   A received-byte item is written to the buffer RAM in its accept cycle unless
//   the buffer already holds RX_DEPTH-1 bytes, and produces nothing; the next
//   item can follow in the next cycle. An idle item runs the reply search: the
//   single RAM read port fetches one byte at a time and one comparator checks it
//   against the pattern; on a match the report fields are fetched the same way,
//   then the report item is loaded.
//   o_in_ready is low while a send or a search is in progress.
//   When the receiver stalls, the output register holds its item and the
//   sequencer waits; nothing is dropped.
//   Reset clears the sequencer, the buffer count and the configuration registers;
//   the buffer RAM needs no clearing pass since unread bytes past the count read
//   as zero. Configuration writes (i_cfg_we) take effect at once and are meant
//   only while the block is idle.
module fingerprint_module_packet_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fpe_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fpe_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TX,
        S_SRD,
        S_SCMP,
        S_FRD,
        S_FCMP,
        S_REPORT
    } t_state;

    // Configuration registers
    logic [31:0] r_address;
    logic [15:0] r_header;
    logic [7:0]  r_cmd_flag;
    logic [7:0]  r_rpl_flag;

    // Sequencer and buffer state
    t_state                   r_state;
    logic [fpe_pkg::RX_CW-1:0] r_cnt;
    logic                     r_done;
    logic [fpe_pkg::RX_AW-1:0] r_p;
    logic [2:0]               r_j;
    logic [2:0]               r_fk;
    logic [4:0]               r_tidx;
    logic [15:0]              r_sum;
    logic [7:0]               r_instr;
    logic [2:0]               r_n;
    logic [39:0]              r_pd;
    logic                     r_found;
    logic [7:0]               r_code;
    logic [15:0]              r_page;
    logic [15:0]              r_score;
    logic                     r_out_valid;
    fpe_pkg::t_out_item       r_out;

    logic                     in_acc;
    logic                     out_free;
    logic                     out_load;
    logic                     ram_we;
    logic [fpe_pkg::RX_AW-1:0] ram_raddr;
    logic [7:0]               ram_rdata;
    logic [fpe_pkg::RX_IW-1:0] s_idx;
    logic [fpe_pkg::RX_IW-1:0] f_idx;
    logic [fpe_pkg::RX_IW-1:0] p_next_end;
    logic [7:0]               pat_byte;
    logic                     pat_hit;
    logic [7:0]               f_byte;
    logic [7:0]               tx_byte;
    logic                     tx_last;
    logic                     tx_in_sum;
    logic [2:0]               n_clip;
    logic [4:0]               n_ext;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = ((r_state == S_TX) || (r_state == S_REPORT)) && out_free;
    assign n_clip     = (i_in_data.param_count > 3'(fpe_pkg::MAX_PARAMS))
                        ? 3'(fpe_pkg::MAX_PARAMS) : i_in_data.param_count;
    assign n_ext      = {2'b00, r_n};

    // Buffer write on an accepted received byte
    assign ram_we = in_acc && (i_in_data.command == fpe_pkg::CMD_RX) && !r_done;

    // Read addresses for the search and for the field fetch
    assign s_idx      = fpe_pkg::RX_IW'(r_p) + fpe_pkg::RX_IW'(r_j);
    assign f_idx      = fpe_pkg::RX_IW'(r_p) + fpe_pkg::RX_IW'(fpe_pkg::CONFIRM_OFS)
                        + fpe_pkg::RX_IW'(r_fk);
    assign p_next_end = fpe_pkg::RX_IW'(r_p) + fpe_pkg::RX_IW'(1)
                        + fpe_pkg::RX_IW'(fpe_pkg::PAT_LEN);
    assign ram_raddr  = (r_state == S_FRD || r_state == S_FCMP)
                        ? f_idx[fpe_pkg::RX_AW-1:0] : s_idx[fpe_pkg::RX_AW-1:0];

    fpe_ram #(
        .WIDTH (8),
        .DEPTH (fpe_pkg::RX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[fpe_pkg::RX_AW-1:0]),
        .i_wdata (i_in_data.rx_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Pattern byte for the current compare step
    always_comb begin
        unique case (r_j)
            3'd0:    pat_byte = r_header[15:8];
            3'd1:    pat_byte = r_header[7:0];
            3'd2:    pat_byte = r_address[31:24];
            3'd3:    pat_byte = r_address[23:16];
            3'd4:    pat_byte = r_address[15:8];
            3'd5:    pat_byte = r_address[7:0];
            default: pat_byte = r_rpl_flag;
        endcase
    end

    // Shared byte comparator
    assign pat_hit = (ram_rdata == pat_byte);

    // Field bytes past the count read as zero
    assign f_byte = (f_idx < fpe_pkg::RX_IW'(r_cnt)) ? ram_rdata : 8'h00;

    // Transmit byte selection
    always_comb begin
        tx_last   = (r_tidx == 5'(fpe_pkg::TX_FIXED + 1) + n_ext);
        tx_in_sum = (r_tidx >= 5'd6) && (r_tidx < 5'(fpe_pkg::TX_FIXED) + n_ext);
        unique case (r_tidx)
            5'd0:    tx_byte = r_header[15:8];
            5'd1:    tx_byte = r_header[7:0];
            5'd2:    tx_byte = r_address[31:24];
            5'd3:    tx_byte = r_address[23:16];
            5'd4:    tx_byte = r_address[15:8];
            5'd5:    tx_byte = r_address[7:0];
            5'd6:    tx_byte = r_cmd_flag;
            5'd7:    tx_byte = 8'h00;
            5'd8:    tx_byte = {5'b00000, r_n} + 8'(fpe_pkg::LEN_EXTRA);
            5'd9:    tx_byte = r_instr;
            default: begin
                if (r_tidx < 5'(fpe_pkg::TX_FIXED) + n_ext) begin
                    tx_byte = r_pd[39:32];
                end else if (r_tidx == 5'(fpe_pkg::TX_FIXED) + n_ext) begin
                    tx_byte = r_sum[15:8];
                end else begin
                    tx_byte = r_sum[7:0];
                end
            end
        endcase
    end

    function automatic logic [2:0] map_status(input logic [7:0] code);
        logic [2:0] st;
        if (code <= fpe_pkg::CODE_MAX_PLAIN) begin
            st = code[2:0];
        end else if (code == fpe_pkg::CODE_DELETE) begin
            st = fpe_pkg::ST_DELETE_FAIL;
        end else begin
            st = fpe_pkg::ST_OTHER;
        end
        return st;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address  <= fpe_pkg::RST_ADDRESS;
            r_header   <= fpe_pkg::RST_HEADER;
            r_cmd_flag <= fpe_pkg::RST_CMD_FLAG;
            r_rpl_flag <= fpe_pkg::RST_RPL_FLAG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fpe_pkg::REG_ADDRESS:  r_address  <= i_cfg_data;
                fpe_pkg::REG_HEADER:   r_header   <= i_cfg_data[15:0];
                fpe_pkg::REG_CMD_FLAG: r_cmd_flag <= i_cfg_data[7:0];
                fpe_pkg::REG_RPL_FLAG: r_rpl_flag <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer, buffer count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Output valid: set on a load, cleared once the item is taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in_data.command)
                            fpe_pkg::CMD_SEND: begin
                                r_instr <= i_in_data.instruction;
                                r_n     <= n_clip;
                                r_pd    <= i_in_data.param_data;
                                r_tidx  <= '0;
                                r_sum   <= '0;
                                r_state <= S_TX;
                            end
                            fpe_pkg::CMD_RX: begin
                                if (!r_done) begin
                                    r_cnt <= r_cnt + 1'b1;
                                    if ((r_cnt + 1'b1)
                                        >= fpe_pkg::RX_CW'(fpe_pkg::RX_DEPTH - 1)) begin
                                        r_done <= 1'b1;
                                    end
                                end
                            end
                            fpe_pkg::CMD_IDLE: begin
                                r_p     <= '0;
                                r_j     <= '0;
                                r_found <= 1'b0;
                                r_code  <= '0;
                                r_page  <= '0;
                                r_score <= '0;
                                if (r_cnt >= fpe_pkg::RX_CW'(fpe_pkg::PAT_LEN)) begin
                                    r_state <= S_SRD;
                                end else begin
                                    r_state <= S_REPORT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TX: begin
                    if (out_free) begin
                        r_out.kind           <= fpe_pkg::KIND_TX;
                        r_out.tx_byte        <= tx_byte;
                        r_out.last           <= tx_last;
                        r_out.reply_found    <= 1'b0;
                        r_out.reply_status   <= '0;
                        r_out.confirm_code   <= '0;
                        r_out.page_number    <= '0;
                        r_out.match_score    <= '0;
                        r_tidx               <= r_tidx + 1'b1;
                        if (tx_in_sum) begin
                            r_sum <= r_sum + {8'h00, tx_byte};
                        end
                        if (r_tidx >= 5'(fpe_pkg::TX_FIXED)) begin
                            r_pd <= {r_pd[31:0], 8'h00};
                        end
                        if (tx_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (pat_hit) begin
                        if (r_j == 3'(fpe_pkg::PAT_LEN - 1)) begin
                            r_found <= 1'b1;
                            r_fk    <= '0;
                            r_state <= S_FRD;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_SRD;
                        end
                    end else begin
                        r_p <= r_p + 1'b1;
                        r_j <= '0;
                        if (p_next_end > fpe_pkg::RX_IW'(r_cnt)) begin
                            r_state <= S_REPORT;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_FRD: begin
                    r_state <= S_FCMP;
                end
                S_FCMP: begin
                    unique case (r_fk)
                        3'd0:    r_code        <= f_byte;
                        3'd1:    r_page[15:8]  <= f_byte;
                        3'd2:    r_page[7:0]   <= f_byte;
                        3'd3:    r_score[15:8] <= f_byte;
                        default: r_score[7:0]  <= f_byte;
                    endcase
                    if (r_fk == 3'(fpe_pkg::FIELD_CNT - 1)) begin
                        r_state <= S_REPORT;
                    end else begin
                        r_fk    <= r_fk + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_out.kind         <= fpe_pkg::KIND_REPORT;
                        r_out.tx_byte      <= 8'h00;
                        r_out.last         <= 1'b1;
                        r_out.reply_found  <= r_found;
                        r_out.reply_status <= r_found ? map_status(r_code)
                                                      : fpe_pkg::ST_NOT_FOUND;
                        r_out.confirm_code <= r_code;
                        r_out.page_number  <= r_page;
                        r_out.match_score  <= r_score;
                        r_cnt              <= '0;
                        r_done             <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[src/fpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module fpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/fpe_checker.sv]
// Port-level checker for the fingerprint module packet engine, bound to the top level.
// Depends on fpe_pkg and fingerprint_module_packet_engine.
`timescale 1ns / 1ps

module fpe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fpe_pkg::t_out_item o_out_data
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result item changed");

    // A report is always the last item of its run and carries no transmit byte
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == fpe_pkg::KIND_REPORT)
        |-> o_out_data.last && (o_out_data.tx_byte == 8'h00))
        else $error("report item not marked last");

    // Transmit items carry zero report fields
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == fpe_pkg::KIND_TX)
        |-> !o_out_data.reply_found && (o_out_data.reply_status == 3'd0)
            && (o_out_data.confirm_code == 8'h00) && (o_out_data.page_number == 16'h0000)
            && (o_out_data.match_score == 16'h0000))
        else $error("transmit item with report fields set");

    // A missing reply reports the not-found status and a zero confirmation code
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == fpe_pkg::KIND_REPORT) && !o_out_data.reply_found
        |-> (o_out_data.reply_status == fpe_pkg::ST_NOT_FOUND)
            && (o_out_data.confirm_code == 8'h00))
        else $error("not-found report inconsistent");

    // A found reply maps its confirmation code to the status
    a_status_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == fpe_pkg::KIND_REPORT) && o_out_data.reply_found
        |-> ((o_out_data.confirm_code <= fpe_pkg::CODE_MAX_PLAIN)
                && (o_out_data.reply_status == o_out_data.confirm_code[2:0]))
            || ((o_out_data.confirm_code == fpe_pkg::CODE_DELETE)
                && (o_out_data.reply_status == fpe_pkg::ST_DELETE_FAIL))
            || ((o_out_data.confirm_code > fpe_pkg::CODE_MAX_PLAIN)
                && (o_out_data.confirm_code != fpe_pkg::CODE_DELETE)
                && (o_out_data.reply_status == fpe_pkg::ST_OTHER)))
        else $error("reply status does not match confirmation code");

endmodule

bind fingerprint_module_packet_engine fpe_checker u_fpe_checker (.*);

[tb/fpe_packet_checker.sv]
// Checker for the fingerprint module packet engine: frames expected packets, tracks the
// receive buffer, searches replies and compares every result item. Depends on fpe_pkg.
`timescale 1ns / 1ps

module fpe_packet_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  fpe_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  fpe_pkg::t_out_item i_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_err_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_found
);
    import fpe_pkg::*;

    // Checksum covers the packet from the flag byte on
    localparam int SUM_FROM = 6;

    // Own copy of the registers
    logic [31:0] addr_q;
    logic [15:0] hdr_q;
    logic [7:0]  cflag_q;
    logic [7:0]  rflag_q;

    // Own copy of the receive buffer
    logic [7:0] rx_mem [RX_DEPTH];
    int         rx_cnt;
    bit         rx_full;

    t_out_item due_items [$];
    int        err_cnt;
    int        checked_cnt;
    int        found_cnt;

    // Bytes at or past the count read as zero
    function automatic logic [7:0] stored_byte(input int idx);
        if (idx < rx_cnt && idx < RX_DEPTH) return rx_mem[idx];
        return 8'h00;
    endfunction

    // Transmit items of one command packet
    task automatic frame_command(input t_in_item it);
        logic [7:0]  pkt [$];
        logic [15:0] len;
        logic [15:0] sum;
        t_out_item   r;
        int          n;
        int          k;
        n   = (it.param_count > MAX_PARAMS) ? MAX_PARAMS : int'(it.param_count);
        len = 16'(n + LEN_EXTRA);
        pkt.push_back(hdr_q[15:8]);
        pkt.push_back(hdr_q[7:0]);
        pkt.push_back(addr_q[31:24]);
        pkt.push_back(addr_q[23:16]);
        pkt.push_back(addr_q[15:8]);
        pkt.push_back(addr_q[7:0]);
        pkt.push_back(cflag_q);
        pkt.push_back(len[15:8]);
        pkt.push_back(len[7:0]);
        pkt.push_back(it.instruction);
        for (k = 0; k < n; k++) pkt.push_back(it.param_data[39 - 8*k -: 8]);
        sum = '0;
        for (k = SUM_FROM; k < pkt.size(); k++) sum += 16'(pkt[k]);
        pkt.push_back(sum[15:8]);
        pkt.push_back(sum[7:0]);
        for (k = 0; k < pkt.size(); k++) begin
            r         = '0;
            r.kind    = KIND_TX;
            r.tx_byte = pkt[k];
            r.last    = (k == pkt.size() - 1);
            due_items.push_back(r);
        end
    endtask

    // Reply search at the end of a reply, then the buffer is cleared
    task automatic search_reply();
        logic [7:0] pat [PAT_LEN];
        logic [7:0] code;
        t_out_item  rep;
        int         at;
        int         p;
        int         j;
        bit         hit;
        pat = '{hdr_q[15:8], hdr_q[7:0], addr_q[31:24], addr_q[23:16],
                addr_q[15:8], addr_q[7:0], rflag_q};
        at = -1;
        for (p = 0; at < 0 && p + PAT_LEN <= rx_cnt; p++) begin
            hit = 1'b1;
            for (j = 0; j < PAT_LEN; j++) begin
                if (stored_byte(p + j) != pat[j]) hit = 1'b0;
            end
            if (hit) at = p;
        end
        rep      = '0;
        rep.kind = KIND_REPORT;
        rep.last = 1'b1;
        if (at >= 0) begin
            code              = stored_byte(at + CONFIRM_OFS);
            rep.reply_found   = 1'b1;
            rep.reply_status  = (code <= CODE_MAX_PLAIN) ? code[2:0] :
                                (code == CODE_DELETE) ? ST_DELETE_FAIL : ST_OTHER;
            rep.confirm_code  = code;
            rep.page_number   = {stored_byte(at + CONFIRM_OFS + 1),
                                 stored_byte(at + CONFIRM_OFS + 2)};
            rep.match_score   = {stored_byte(at + CONFIRM_OFS + 3),
                                 stored_byte(at + CONFIRM_OFS + 4)};
            found_cnt++;
        end else begin
            rep.reply_status = ST_NOT_FOUND;
        end
        due_items.push_back(rep);
        rx_cnt  = 0;
        rx_full = 1'b0;
    endtask

    task automatic cmp(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            addr_q  = RST_ADDRESS;
            hdr_q   = RST_HEADER;
            cflag_q = RST_CMD_FLAG;
            rflag_q = RST_RPL_FLAG;
            rx_cnt  = 0;
            rx_full = 1'b0;
            due_items.delete();
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ADDRESS:  addr_q  = i_cfg_data;
                    REG_HEADER:   hdr_q   = i_cfg_data[15:0];
                    REG_CMD_FLAG: cflag_q = i_cfg_data[7:0];
                    REG_RPL_FLAG: rflag_q = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Accepted input item
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.command)
                    CMD_SEND: frame_command(i_in_data);
                    CMD_RX: begin
                        if (!rx_full) begin
                            if (rx_cnt < RX_DEPTH) rx_mem[rx_cnt] = i_in_data.rx_byte;
                            rx_cnt++;
                            if (rx_cnt >= RX_DEPTH - 1) rx_full = 1'b1;
                        end
                    end
                    CMD_IDLE: search_reply();
                    default: ;
                endcase
            end
            // Accepted result item
            if (i_out_valid && i_out_ready) begin
                if (due_items.size() == 0) begin
                    $error("unexpected result item: kind %0d tx_byte 0x%0h",
                           i_out_data.kind, i_out_data.tx_byte);
                    err_cnt++;
                end else begin
                    want = due_items.pop_front();
                    cmp("kind", 16'(want.kind), 16'(i_out_data.kind));
                    cmp("tx_byte", 16'(want.tx_byte), 16'(i_out_data.tx_byte));
                    cmp("last", 16'(want.last), 16'(i_out_data.last));
                    cmp("reply_found", 16'(want.reply_found), 16'(i_out_data.reply_found));
                    cmp("reply_status", 16'(want.reply_status), 16'(i_out_data.reply_status));
                    cmp("confirm_code", 16'(want.confirm_code), 16'(i_out_data.confirm_code));
                    cmp("page_number", want.page_number, i_out_data.page_number);
                    cmp("match_score", want.match_score, i_out_data.match_score);
                    checked_cnt++;
                end
            end
        end
        o_pending   <= due_items.size();
        o_err_count <= err_cnt;
        o_checked   <= checked_cnt;
        o_found     <= found_cnt;
    end

endmodule

[tb/tb.sv]
// Testbench top for the fingerprint module packet engine: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on fpe_pkg, fpe_packet_checker and the engine.
`timescale 1ns / 1ps

module tb;
    import fpe_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 20;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int PHASES          = 5;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_ADDRESS;
    logic [31:0] cfg_data  = '0;

    int err_count;
    int pending;
    int checked;
    int found;

    // Stimulus-side view of the registers, used to build replies
    logic [31:0] cur_addr  = RST_ADDRESS;
    logic [15:0] cur_hdr   = RST_HEADER;
    logic [7:0]  cur_rflag = RST_RPL_FLAG;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int n_items, n_send, n_rx, n_idle, rx_fill;

    always #5 clk = ~clk;

    fingerprint_module_packet_engine u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fpe_packet_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_found     (found)
    );

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Every field random except the command and the received byte
    function automatic t_in_item make_item(input logic [1:0] cmd, input logic [7:0] rxb);
        t_in_item it;
        it.command     = cmd;
        it.instruction = 8'($urandom);
        it.param_count = 3'($urandom_range(0, 7));
        it.param_data  = {8'($urandom), 32'($urandom)};
        it.rx_byte     = rxb;
        return it;
    endfunction

    function automatic t_in_item make_send();
        t_in_item it;
        it = make_item(CMD_SEND, 8'($urandom));
        it.param_count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
        return it;
    endfunction

    // Offer one item and hold it until accepted
    task automatic push_item(input t_in_item it);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        case (it.command)
            CMD_SEND: begin n_send++; n_items++; end
            CMD_RX: begin
                // bytes past a nearly full buffer are ignored by the block
                if (rx_fill < RX_DEPTH - 1) begin
                    rx_fill++;
                    n_items++;
                end
                n_rx++;
            end
            CMD_IDLE: begin rx_fill = 0; n_idle++; n_items++; end
            default: ;
        endcase
    endtask

    task automatic push_idle();
        push_item(make_item(CMD_IDLE, 8'($urandom)));
    endtask

    // Wait until every predicted result has left the block
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] addr, input logic [15:0] hdr,
                              input logic [7:0] cflag, input logic [7:0] rflag);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_index <= REG_HEADER;
        cfg_data  <= {16'h0000, hdr};
        @(posedge clk);
        cfg_index <= REG_CMD_FLAG;
        cfg_data  <= {24'h000000, cflag};
        @(posedge clk);
        cfg_index <= REG_RPL_FLAG;
        cfg_data  <= {24'h000000, rflag};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_addr  = addr;
        cur_hdr   = hdr;
        cur_rflag = rflag;
    endtask

    function automatic logic [7:0] pattern_byte(input int k);
        logic [7:0] pat [PAT_LEN];
        pat = '{cur_hdr[15:8], cur_hdr[7:0], cur_addr[31:24], cur_addr[23:16],
                cur_addr[15:8], cur_addr[7:0], cur_rflag};
        return pat[k];
    endfunction

    // A reply packet with random content, sometimes damaged or cut short
    task automatic send_reply();
        logic [7:0] msg [$];
        logic [7:0] code;
        int         r;
        int         n;
        int         k;
        int         pat_end;
        r = $urandom_range(0, 3);
        if (r == 1) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) msg.push_back(8'($urandom));
        end else if (r == 2) begin
            // partial pattern first, so the search has to restart
            n = $urandom_range(1, PAT_LEN - 1);
            for (k = 0; k < n; k++) msg.push_back(pattern_byte(k));
        end
        for (k = 0; k < PAT_LEN; k++) msg.push_back(pattern_byte(k));
        pat_end = msg.size();
        if ($urandom_range(0, 4) == 0) begin
            k = pat_end - 1 - $urandom_range(0, PAT_LEN - 1);
            msg[k] = msg[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        msg.push_back(8'h00);
        msg.push_back(8'($urandom_range(3, 7)));
        case ($urandom_range(0, 6))
            0, 1, 2, 3: code = 8'($urandom_range(0, 3));
            4:          code = CODE_DELETE;
            5:          code = ($urandom_range(0, 1) != 0) ? 8'h04 : 8'h11;
            default:    code = 8'($urandom);
        endcase
        msg.push_back(code);
        for (k = 0; k < 6; k++) msg.push_back(8'($urandom));
        // short reply: fields past the end read as zero
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(pat_end, msg.size() - 1);
            while (msg.size() > n) void'(msg.pop_back());
        end
        foreach (msg[i]) push_item(make_item(CMD_RX, msg[i]));
        push_idle();
    endtask

    // Fill past the nearly-full point with a pattern close to the end
    task automatic fill_buffer();
        int n;
        int at;
        int k;
        n  = RX_DEPTH + $urandom_range(0, 6);
        at = $urandom_range(40, RX_DEPTH - PAT_LEN);
        for (k = 0; k < n; k++) begin
            if (k >= at && k < at + PAT_LEN) push_item(make_item(CMD_RX, pattern_byte(k - at)));
            else push_item(make_item(CMD_RX, 8'($urandom)));
        end
        push_idle();
    endtask

    // A few bytes, often pattern bytes, then idle
    task automatic send_noise();
        int n;
        int k;
        n = $urandom_range(0, 10);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 1) != 0)
                push_item(make_item(CMD_RX, pattern_byte($urandom_range(0, PAT_LEN - 1))));
            else
                push_item(make_item(CMD_RX, 8'($urandom)));
        end
        push_idle();
    endtask

    // Receiver: random stalls, one long hold on request
    initial begin : receiver
        int lo;
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            lo = quiet ? 0 : pick_gap();
            if (lo > 0) begin
                out_ready <= 1'b0;
                repeat (lo) @(posedge clk);
            end
        end
    end

    // Watchdog: too long with no handshake on any channel
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
                stuck = 0;
            else
                stuck++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        t_in_item it;
        int       ph;
        int       stop_at;
        int       pick;
        int       k;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, parameter clamp, empty and short replies, unused command
        it = make_item(CMD_SEND, 8'h00);
        it.instruction = 8'h00;
        it.param_count = 3'd0;
        it.param_data  = '0;
        push_item(it);
        it = make_item(CMD_SEND, 8'hFF);
        it.instruction = 8'hFF;
        it.param_count = 3'd5;
        it.param_data  = '1;
        push_item(it);
        it = make_send();
        it.param_count = 3'd6;
        push_item(it);
        it = make_send();
        it.param_count = 3'd7;
        push_item(it);
        push_idle();
        it = '1;
        it.command = CMD_NONE;
        push_item(it);
        for (k = 0; k < PAT_LEN; k++) push_item(make_item(CMD_RX, pattern_byte(k)));
        push_idle();
        push_item(make_item(CMD_RX, 8'h00));
        push_item(make_item(CMD_RX, 8'hFF));
        push_idle();

        // Random phases over several register settings
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: write_regs('0, '0, '0, '0);
                2: write_regs('1, '1, '1, '1);
                3: write_regs(32'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
                4: write_regs(RST_ADDRESS, RST_HEADER, RST_CMD_FLAG, RST_RPL_FLAG);
                default: ;
            endcase
            quiet   = (ph == 3);
            stop_at = n_items + ITEMS_PER_PHASE;
            if (ph == 1) begin
                // long receiver hold while packets keep coming
                hold_req = 1'b1;
                quiet    = 1'b1;
                repeat (8) push_item(make_send());
                quiet    = 1'b0;
            end
            while (n_items < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) push_item(make_send());
                else if (pick < 75) send_reply();
                else if (pick < 85) send_noise();
                else if (pick < 90) fill_buffer();
                else if (pick < 95) push_item(make_item(CMD_NONE, 8'($urandom)));
                else push_idle();
            end
        end

        settle();
        quiet = 1'b0;
        repeat (END_CYCLES) @(posedge clk);

        $display("Covered %0d send, %0d received-byte and %0d idle items over %0d settings.",
                 n_send, n_rx, n_idle, PHASES);
        $display("%0d result items checked, %0d replies located.", checked, found);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
